### src/shamp_pkg.sv
package shamp_pkg;

   // Field and storage widths
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 64;
   localparam int WORD_BYTES  = WORD_W / BYTE_W;
   localparam int BLOCK_BYTES = 64;
   localparam int BLOCK_WORDS = BLOCK_BYTES / WORD_BYTES;
   localparam int FILL_W      = $clog2(BLOCK_BYTES);
   localparam int WIDX_W      = $clog2(BLOCK_WORDS);
   localparam int BYTE_POS_W  = $clog2(WORD_BYTES);
   localparam int COUNT_W     = 61;
   localparam int PREFIX_W    = 7;

   // Two banks of one block each: ping-pong between assembly and readout
   localparam int RAM_DEPTH   = 2 * BLOCK_WORDS;
   localparam int RAM_AW      = $clog2(RAM_DEPTH);

   // Longest job: two blocks (full block plus one padding block, or two padding blocks)
   localparam int STEP_W      = 5;

   // Padding constants
   localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;
   localparam int LEN_POS = 56;

   // Port packing
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_PAD_W   = RSP_TDATA_W - WORD_W - WIDX_W;
   localparam int RSP_TUSER_W = 2;

   // One readout job: an optional full block, then optional padding blocks
   typedef struct packed {
      logic                 full_en;
      logic                 two_blk;
      logic                 bank;
      logic [WIDX_W-1:0]    fill_word;
      logic [STEP_W-1:0]    last_step;
      logic [WORD_W-1:0]    partial;
      logic [WORD_W-1:0]    len_word;
   } job_type;

endpackage

### src/shamp_ram.sv
module shamp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/shamp_reader.sv
module shamp_reader (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                job_valid,
   input  shamp_pkg::job_type                  job,
   output logic                                slot_free,
   output logic                                ram_rd_en,
   output logic [shamp_pkg::RAM_AW-1:0]        ram_rd_addr,
   input  logic [shamp_pkg::WORD_W-1:0]        ram_rd_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [shamp_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [shamp_pkg::RSP_TUSER_W-1:0]   rsp_tuser,
   output logic                                rsp_tlast
);
   import shamp_pkg::*;

   typedef struct packed {
      logic              use_ram;
      logic [WIDX_W-1:0] word_index;
      logic              end_of_block;
      logic              message_done;
      logic              run_last;
   } beat_type;

   logic               cur_valid_ff;
   logic               pend_valid_ff;
   job_type            cur_ff;
   job_type            pend_ff;
   logic [STEP_W-1:0]  step_ff;

   logic               s1_valid_ff;
   beat_type           s1_ff;
   logic [WORD_W-1:0]  s1_word_ff;

   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  rsp_word_ff;
   logic [WIDX_W-1:0]  rsp_index_ff;
   logic               rsp_eob_ff;
   logic               rsp_done_ff;
   logic               rsp_last_ff;

   logic               out_load;
   logic               adv;
   logic               is_full;
   logic [STEP_W-1:0]  pad_step;
   logic [WIDX_W:0]    pad_pos;
   logic [WIDX_W:0]    last_pad;
   logic [WIDX_W:0]    fill_pos;
   beat_type           beat;
   logic [WORD_W-1:0]  beat_word;

   assign out_load  = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign adv       = cur_valid_ff && (!s1_valid_ff || out_load);
   assign slot_free = !pend_valid_ff;

   // Step decode: full-block words first, then padding words
   always_comb begin
      is_full  = cur_ff.full_en && (step_ff < STEP_W'(BLOCK_WORDS));
      pad_step = step_ff - (cur_ff.full_en ? STEP_W'(BLOCK_WORDS) : STEP_W'(0));
      pad_pos  = pad_step[WIDX_W:0];
      last_pad = cur_ff.two_blk ? (WIDX_W+1)'(2 * BLOCK_WORDS - 1)
                                : (WIDX_W+1)'(BLOCK_WORDS - 1);
      fill_pos = {1'b0, cur_ff.fill_word};

      beat.use_ram      = is_full || (pad_pos < fill_pos);
      beat.word_index   = is_full ? step_ff[WIDX_W-1:0] : pad_pos[WIDX_W-1:0];
      beat.end_of_block = (beat.word_index == WIDX_W'(BLOCK_WORDS - 1));
      beat.message_done = !is_full && (pad_pos == last_pad);
      beat.run_last     = (step_ff == cur_ff.last_step);

      if (pad_pos == fill_pos) begin
         beat_word = cur_ff.partial;
      end else if (pad_pos == last_pad) begin
         beat_word = cur_ff.len_word;
      end else begin
         beat_word = '0;
      end
   end

   assign ram_rd_en   = adv && beat.use_ram;
   assign ram_rd_addr = {cur_ff.bank, beat.word_index};

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         step_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (adv) begin
            if (step_ff == cur_ff.last_step) begin
               cur_valid_ff <= 1'b0;
               step_ff      <= '0;
            end else begin
               step_ff <= step_ff + STEP_W'(1);
            end
         end
         if (!cur_valid_ff && pend_valid_ff) begin
            cur_valid_ff  <= 1'b1;
            pend_valid_ff <= 1'b0;
         end
         if (job_valid) begin
            if (!cur_valid_ff && !pend_valid_ff) begin
               cur_valid_ff <= 1'b1;
            end else begin
               pend_valid_ff <= 1'b1;
            end
         end
         if (adv) begin
            s1_valid_ff <= 1'b1;
         end else if (out_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!cur_valid_ff && pend_valid_ff) begin
         cur_ff <= pend_ff;
      end else if (job_valid && !cur_valid_ff) begin
         cur_ff <= job;
      end
      if (job_valid && cur_valid_ff) begin
         pend_ff <= job;
      end
      if (adv) begin
         s1_ff      <= beat;
         s1_word_ff <= beat_word;
      end
      if (out_load) begin
         rsp_word_ff  <= s1_ff.use_ram ? ram_rd_data : s1_word_ff;
         rsp_index_ff <= s1_ff.word_index;
         rsp_eob_ff   <= s1_ff.end_of_block;
         rsp_done_ff  <= s1_ff.message_done;
         rsp_last_ff  <= s1_ff.run_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_index_ff, rsp_word_ff};
   assign rsp_tuser  = {rsp_done_ff, rsp_eob_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_no_job_when_full: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> !pend_valid_ff)
      else $error("job offered while pending slot occupied");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (step_ff <= cur_ff.last_step))
      else $error("step counter beyond end of job");

   a_pend_promoted: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && !cur_valid_ff) |=> (cur_valid_ff && !pend_valid_ff))
      else $error("pending job not promoted");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tlast && rsp_tuser[0]))
      else $error("message done without end of block and run end");
`endif

endmodule

### src/sha256_message_padder_top.sv
// SHA-256 message padder.
// Request channel (req_*): one message byte per request. req_tdata holds the
// byte, req_tuser[0] says whether the byte is present (0 allows an empty
// message) and req_tlast closes the message after this request's byte.
// Response channel (rsp_*): 64-bit block words, eight per 64-byte block,
// byte 8i+k of the block at bits 8k+7..8k. Each full block goes out as soon
// as its last byte arrives; at end of message one padding block follows, or
// two when 56 or more bytes are pending (0x80, zeros, big-endian bit length).
// csr_wr_en/csr_wr_data load the prefix byte count that is added into the
// length field (HMAC inner hash); write it only while the block is idle.
// Throughput: one request per cycle while bytes stream and the job slot is
// free. The block buffer is a two-bank RAM: one bank is filled while the
// reader drains the other, one word per cycle while the receiver is ready.
// With the reader idle, a job enters at the edge that takes the request ending
// its block or message; each word then passes a read stage and the output register.
// A job that finds the reader busy waits in a one-entry slot; while that slot
// is occupied req_tready is low, and the next request waits on readout.
// Reset is synchronous and clears counts, prefix and the job queue; RAM
// contents are not cleared. A stalled receiver freezes the output register
// and the read pipeline, and back-pressure reaches req_tready once the slot fills.
module sha256_message_padder_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [shamp_pkg::PREFIX_W-1:0]        csr_wr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [shamp_pkg::REQ_TDATA_W-1:0]     req_tdata,   // [7:0] data_byte
   input  logic [0:0]                            req_tuser,   // [0] byte_present
   input  logic                                  req_tlast,   // end_of_message
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [shamp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,   // [63:0] block_word,
                                                              // [66:64] word_index
   output logic [shamp_pkg::RSP_TUSER_W-1:0]     rsp_tuser,   // [0] end_of_block,
                                                              // [1] message_done
   output logic                                  rsp_tlast    // run_last
);
   import shamp_pkg::*;

   logic [PREFIX_W-1:0]   prefix_ff;
   logic [FILL_W-1:0]     fill_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic                  bank_ff;
   logic [WORD_W-1:0]     acc_ff;
   logic [WORD_W-1:0]     acc_in;

   logic                  accept;
   logic                  present;
   logic                  eom;
   logic [BYTE_W-1:0]     data_byte;
   logic                  blk_full;
   logic                  issue;
   logic [FILL_W-1:0]     fill_after;
   logic [COUNT_W-1:0]    count_next;
   logic [COUNT_W-1:0]    len_sum;
   logic [WORD_W-1:0]     len_bits;
   job_type               job;
   logic                  slot_free;

   logic                  ram_we;
   logic [RAM_AW-1:0]     ram_wr_addr;
   logic                  ram_rd_en;
   logic [RAM_AW-1:0]     ram_rd_addr;
   logic [WORD_W-1:0]     ram_rd_data;

   assign present   = req_tuser[0];
   assign eom       = req_tlast;
   assign data_byte = req_tdata[BYTE_W-1:0];
   assign req_tready = slot_free;
   assign accept    = req_tvalid && req_tready;

   // Byte lands in the word being assembled
   always_comb begin
      for (int k = 0; k < WORD_BYTES; k++) begin
         acc_in[BYTE_W*k +: BYTE_W] =
            (present && (fill_ff[BYTE_POS_W-1:0] == BYTE_POS_W'(k))) ?
            data_byte : acc_ff[BYTE_W*k +: BYTE_W];
      end
   end

   assign fill_after = fill_ff + FILL_W'(present);
   assign blk_full   = present && (fill_ff == FILL_W'(BLOCK_BYTES - 1));
   assign count_next = count_ff + COUNT_W'(present);
   assign len_sum    = count_ff + COUNT_W'(prefix_ff) + COUNT_W'(present);
   assign len_bits   = {len_sum, 3'b000};
   assign issue      = accept && (blk_full || eom);

   // Word write when its eighth byte arrives
   assign ram_we      = accept && present &&
                        (fill_ff[BYTE_POS_W-1:0] == BYTE_POS_W'(WORD_BYTES - 1));
   assign ram_wr_addr = {bank_ff, fill_ff[FILL_W-1:BYTE_POS_W]};

   // Job descriptor: partial word with pad mark, byte-swapped length
   always_comb begin
      job.full_en   = blk_full;
      job.two_blk   = (fill_after >= FILL_W'(LEN_POS));
      job.bank      = bank_ff;
      job.fill_word = fill_after[FILL_W-1:BYTE_POS_W];
      job.last_step = (blk_full ? STEP_W'(BLOCK_WORDS) : STEP_W'(0))
                    + (eom ? (job.two_blk ? STEP_W'(2 * BLOCK_WORDS) : STEP_W'(BLOCK_WORDS))
                           : STEP_W'(0))
                    - STEP_W'(1);
      for (int k = 0; k < WORD_BYTES; k++) begin
         if (BYTE_POS_W'(k) < fill_after[BYTE_POS_W-1:0]) begin
            job.partial[BYTE_W*k +: BYTE_W] = acc_in[BYTE_W*k +: BYTE_W];
         end else if (BYTE_POS_W'(k) == fill_after[BYTE_POS_W-1:0]) begin
            job.partial[BYTE_W*k +: BYTE_W] = PAD_MARK;
         end else begin
            job.partial[BYTE_W*k +: BYTE_W] = '0;
         end
         job.len_word[BYTE_W*k +: BYTE_W] =
            len_bits[BYTE_W*(WORD_BYTES-1-k) +: BYTE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= '0;
         fill_ff   <= '0;
         count_ff  <= '0;
         bank_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            prefix_ff <= csr_wr_data;
         end
         if (accept) begin
            fill_ff  <= eom ? '0 : fill_after;
            count_ff <= eom ? '0 : count_next;
         end
         if (issue) begin
            bank_ff <= ~bank_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         acc_ff <= acc_in;
      end
   end

   shamp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (acc_in),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   shamp_reader u_reader (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (issue),
      .job         (job),
      .slot_free   (slot_free),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   a_bank_split: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_rd_en) |-> (ram_wr_addr[RAM_AW-1] != ram_rd_addr[RAM_AW-1]))
      else $error("assembly and readout hit the same bank");

   a_counts_cleared: assert property (@(posedge clock) disable iff (reset)
      (accept && eom) |=> ((fill_ff == '0) && (count_ff == '0)))
      else $error("counts not cleared after message end");

   a_bank_flips: assert property (@(posedge clock) disable iff (reset)
      issue |=> (bank_ff != $past(bank_ff)))
      else $error("bank not switched after job issue");
`endif

endmodule

### sim/sha256_message_padder_checker.sv
module sha256_message_padder_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [shamp_pkg::PREFIX_W-1:0]    csr_wr_data,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [shamp_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [0:0]                        req_tuser,
   input  logic                              req_tlast,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [shamp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [shamp_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                              rsp_tlast,
   output int                                fail_count,
   output int                                words_pending,
   output int                                words_checked
);
   import shamp_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0] data;
      logic [WIDX_W-1:0] position;
      logic              block_end;
      logic              msg_done;
      logic              step_last;
   } block_word_type;

   block_word_type      expected_words[$];
   logic [BYTE_W-1:0]   assembly [BLOCK_BYTES];
   logic [BYTE_W-1:0]   frame [2*BLOCK_BYTES];
   int unsigned         fill_level;
   logic [COUNT_W-1:0]  msg_bytes;
   logic [PREFIX_W-1:0] prefix;

   initial begin
      fail_count    = 0;
      words_pending = 0;
      words_checked = 0;
   end

   // Queue the eight words of the block that starts at frame[base].
   task automatic push_block(input int base, input logic closes);
      block_word_type w;
      int             i;
      int             k;
      for (i = 0; i < BLOCK_WORDS; i++) begin
         w.data = '0;
         for (k = 0; k < WORD_BYTES; k++)
            w.data[BYTE_W*k +: BYTE_W] = frame[base + WORD_BYTES*i + k];
         w.position  = i[WIDX_W-1:0];
         w.block_end = (i == BLOCK_WORDS - 1);
         w.msg_done  = closes && (i == BLOCK_WORDS - 1);
         w.step_last = 1'b0;
         expected_words.push_back(w);
      end
   endtask

   task automatic absorb_request(input logic [BYTE_W-1:0] data, input logic present,
                                 input logic closes);
      int             first;
      int             blocks;
      int             len_at;
      int             i;
      logic [63:0]    bit_len;
      block_word_type tail;
      first = expected_words.size();
      if (present) begin
         assembly[fill_level] = data;
         fill_level++;
         msg_bytes++;
         if (fill_level == BLOCK_BYTES) begin
            for (i = 0; i < BLOCK_BYTES; i++)
               frame[i] = assembly[i];
            push_block(0, 1'b0);
            fill_level = 0;
         end
      end
      if (closes) begin
         // length in bits wraps at 64 bits; prefix only enters the length
         bit_len = ({{(64-PREFIX_W){1'b0}}, prefix} +
                    {{(64-COUNT_W){1'b0}}, msg_bytes}) << 3;
         blocks  = (fill_level < LEN_POS) ? 1 : 2;
         for (i = 0; i < 2*BLOCK_BYTES; i++)
            frame[i] = (i < fill_level) ? assembly[i] : 8'h00;
         frame[fill_level] = PAD_MARK;
         len_at = blocks * BLOCK_BYTES - 8;
         for (i = 0; i < 8; i++)
            frame[len_at + 7 - i] = bit_len[8*i +: 8];
         if (blocks == 2)
            push_block(0, 1'b0);
         push_block((blocks - 1) * BLOCK_BYTES, 1'b1);
         fill_level = 0;
         msg_bytes  = '0;
      end
      if (expected_words.size() > first) begin
         tail = expected_words.pop_back();
         tail.step_last = 1'b1;
         expected_words.push_back(tail);
      end
   endtask

   task automatic check_word();
      block_word_type got;
      block_word_type want;
      got.data      = rsp_tdata[WORD_W-1:0];
      got.position  = rsp_tdata[WORD_W +: WIDX_W];
      got.block_end = rsp_tuser[0];
      got.msg_done  = rsp_tuser[1];
      got.step_last = rsp_tlast;
      if (expected_words.size() == 0) begin
         fail_count++;
         $display("%0t: unexpected word: expected none", $time);
         $display("%0t:   got data=%h idx=%0d eob=%b done=%b last=%b",
                  $time, got.data, got.position, got.block_end, got.msg_done,
                  got.step_last);
      end else begin
         want = expected_words.pop_front();
         words_checked++;
         if (got.data !== want.data || got.position !== want.position ||
             got.block_end !== want.block_end || got.msg_done !== want.msg_done ||
             got.step_last !== want.step_last) begin
            fail_count++;
            $display("%0t: mismatch: expected data=%h idx=%0d eob=%b done=%b last=%b",
                     $time, want.data, want.position, want.block_end, want.msg_done,
                     want.step_last);
            $display("%0t:           got data=%h idx=%0d eob=%b done=%b last=%b",
                     $time, got.data, got.position, got.block_end, got.msg_done,
                     got.step_last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_words.delete();
         fill_level = 0;
         msg_bytes  = '0;
         prefix     = '0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_word();
         if (csr_wr_en)
            prefix = csr_wr_data;
         if (req_tvalid && req_tready)
            absorb_request(req_tdata[BYTE_W-1:0], req_tuser[0], req_tlast);
      end
      words_pending = expected_words.size();
   end

endmodule

### sim/tb_sha256_message_padder_top.sv
module tb_sha256_message_padder_top;
   import shamp_pkg::*;

   localparam int HOLD_CYCLES  = 300;   // one long receiver hold-off
   localparam int DRAIN_CYCLES = 24;    // settle time after the last word
   localparam int QUIET_LIMIT  = 3000;  // watchdog: cycles with no transfer
   localparam int PHASE_ITEMS  = 55;    // random requests per prefix setting

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [PREFIX_W-1:0]    csr_wr_data = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic [0:0]             req_tuser   = '0;
   logic                   req_tlast   = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;

   int fail_count;
   int words_pending;
   int words_checked;

   // Stimulus bookkeeping
   int burst_left     = 0;
   bit bursty         = 1'b1;
   int requests_sent  = 0;
   int messages_sent  = 0;
   int phase_requests = 0;
   bit hold_req       = 1'b0;
   bit hold_served    = 1'b0;
   int quiet_cycles   = 0;

   sha256_message_padder_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   sha256_message_padder_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .words_pending (words_pending),
      .words_checked (words_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Offer one request, starting and ending at a falling edge. In bursty mode
   // the sender drops tvalid for a random gap whenever a burst runs out, so
   // gaps land on every phase of block assembly and readout.
   task automatic send_request(input logic [7:0] data, input logic present,
                               input logic closes);
      if (bursty && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= data;
      req_tuser[0] <= present;
      req_tlast    <= closes;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0)
         burst_left--;
      if (present || closes) begin
         requests_sent++;
         phase_requests++;
      end
   endtask

   // One message of len bytes. It is closed either on its last byte or by a
   // trailing request without a byte; stray empty requests are mixed in.
   task automatic send_message(input int len, input bit close_on_byte);
      int i;
      if (len == 0)
         close_on_byte = 1'b0;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 11) == 0)
            send_request(8'($urandom), 1'b0, 1'b0);
         send_request(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
      end
      if (!close_on_byte)
         send_request(8'($urandom), 1'b0, 1'b1);
      messages_sent++;
   endtask

   // Mostly short messages; now and then one near the 56- and 64-byte edges
   // of the padding, and occasionally past a full block.
   function automatic int pick_length();
      int lens_one [6];
      int lens_two [3];
      lens_one = '{55, 56, 57, 63, 64, 65};
      lens_two = '{119, 120, 127};
      case ($urandom_range(0, 11))
         0, 1, 2, 3, 4, 5, 6: return $urandom_range(0, 12);
         7, 8:                return lens_one[$urandom_range(0, 5)];
         9:                   return lens_two[$urandom_range(0, 2)];
         default:             return $urandom_range(13, 40);
      endcase
   endfunction

   // Park the sender until every predicted word is out, then let the read
   // pipeline settle so the block is truly idle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_prefix(input logic [PREFIX_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Receiver: the stall style is redrawn at random as cycle_no advances; one long hold-off on
   // request from the stimulus, counted here.
   initial begin
      int cycle_no;
      int stall_mode;
      int stall_left;
      cycle_no   = 0;
      stall_mode = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_served) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_served = 1'b1;
         end else begin
            cycle_no++;
            if (cycle_no % 160 == 0)
               stall_mode = $urandom_range(0, 3);
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (cycle_no % 3 != 0);
               default: begin
                  if (stall_left > 0) begin
                     rsp_tready <= 1'b0;
                     stall_left--;
                  end else begin
                     rsp_tready <= 1'b1;
                     if ($urandom_range(0, 15) == 0)
                        stall_left = $urandom_range(1, 12);
                  end
               end
            endcase
         end
      end
   end

   // Watchdog: ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("tb_sha256_message_padder_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                  phase;
      logic [PREFIX_W-1:0] settings [4];
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, prefix at its reset value of zero.
      send_request(8'h3C, 1'b0, 1'b0);       // no byte, no end: ignored
      send_request(8'hC3, 1'b0, 1'b1);       // empty message
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'hFF, 1'b1, 1'b0);
      send_request(8'h5A, 1'b1, 1'b1);       // three bytes, closed on a byte
      send_request(8'h11, 1'b1, 1'b0);
      send_request(8'hEE, 1'b0, 1'b0);       // stray empty request mid-message
      send_request(8'h96, 1'b0, 1'b1);       // closed by a request without a byte
      // Largest prefix, beyond one block: enters the length only.
      write_prefix(7'd127);
      send_request(8'h80, 1'b1, 1'b1);
      send_request(8'h7F, 1'b0, 1'b1);
      write_prefix(7'd65);
      send_request(8'hA5, 1'b1, 1'b0);
      send_request(8'h5A, 1'b1, 1'b1);

      // Random part: one phase per prefix setting, the first three opened by a
      // message on a padding edge, with an idle drain between phases.
      settings = '{7'd64, 7'd0, 7'($urandom_range(0, 127)), 7'($urandom_range(1, 63))};
      for (phase = 0; phase < 4; phase++) begin
         write_prefix(settings[phase]);
         phase_requests = 0;
         bursty = (phase != 2);
         case (phase)
            0: send_message(56, 1'b1);        // two padding blocks
            1: begin
               // hold the receiver while a full block that also ends the
               // message goes in; the sender keeps offering after it
               hold_req = 1'b1;
               send_message(64, 1'b1);
            end
            2: send_message(55, 1'b0);        // last length with one padding block
            default: send_message(pick_length(), 1'b1);
         endcase
         while (phase_requests < PHASE_ITEMS || (hold_req && !hold_served))
            send_message(pick_length(), $urandom_range(0, 3) != 0);
      end

      drain();
      $display("%0d requests in %0d messages, %0d block words checked",
               requests_sent, messages_sent, words_checked);
      $display("prefixes 0, 127, 65, 64 and random; bursty and steady sending; %0d-cycle hold",
               HOLD_CYCLES);
      if (words_pending != 0)
         $display("%0t: %0d expected block words never arrived", $time, words_pending);
      if (fail_count == 0 && words_pending == 0) begin
         $display("tb_sha256_message_padder_top OK");
      end else begin
         $display("tb_sha256_message_padder_top NOT OK");
      end
      $finish;
   end

endmodule

### sha256_message_padder_top.f
src/shamp_pkg.sv
src/shamp_ram.sv
src/shamp_reader.sv
src/sha256_message_padder_top.sv
sim/sha256_message_padder_checker.sv
sim/tb_sha256_message_padder_top.sv
